/* rtl/ipq_pkg.sv */
// Package: shared types, constants and the priority compare for the interrupt queue.
`default_nettype none
package ipq_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Fixed field widths of the item channels
  localparam int unsigned HandlerW   = 8;
  localparam int unsigned DispIdW    = 4;
  localparam int unsigned PendW      = 5;

  // Item kinds
  localparam logic KindRaise   = 1'b0;
  localparam logic KindService = 1'b1;

  typedef struct packed {
    logic                kind;
    logic                is_maskable;
    logic [HandlerW-1:0] handler_index;
    logic                interrupts_disabled;
  } in_item_t;

  typedef struct packed {
    logic                dispatched;
    logic [HandlerW-1:0] dispatch_handler;
    logic [DispIdW-1:0]  dispatch_id;
    logic                overflow;
    logic [PendW-1:0]    pending_count;
  } out_item_t;

  typedef struct packed {
    logic                maskable;
    logic [HandlerW-1:0] handler;
    logic [IdW-1:0]      id;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // update the queue and write the result register
  } ipq_cmd_t;

  typedef enum logic [0:0] {
    StIdle,
    StExec
  } ctrl_state_e;

  // True when entry a has higher priority than entry b
  function automatic logic goes_before(logic am, logic [IdW-1:0] aid,
                                       logic bm, logic [IdW-1:0] bid);
    logic res;
    if (am != bm) begin
      res = (am < bm);
    end else begin
      res = (aid < bid);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* rtl/ipq_ctrl.sv */
// Controller: accept and execute sequencing plus the result valid flag.
`default_nettype none
module ipq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ipq_pkg::ipq_cmd_t      cmd_o
);

  ipq_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  // Result register can take a new item when empty or being drained
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipq_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = ipq_pkg::StExec;
        end
      end
      ipq_pkg::StExec: begin
        if (slot_free) begin
          state_d = ipq_pkg::StIdle;
        end
      end
      default: state_d = ipq_pkg::StIdle;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ipq_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ipq_pkg::StExec: begin
        cmd_o.exec = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Set valid on execute, drop it once the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipq_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* rtl/ipq_datapath.sv */
// Datapath: sorted shift-register queue, entry count, item and result registers.
`default_nettype none
module ipq_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ipq_pkg::ipq_cmd_t   cmd_i,
  input  wire ipq_pkg::in_item_t   in_item_i,
  output ipq_pkg::out_item_t       out_item_o
);

  localparam int unsigned Depth = ipq_pkg::QueueDepth;

  ipq_pkg::in_item_t          item_q;
  ipq_pkg::entry_t            entry_q [Depth];
  ipq_pkg::entry_t            entry_d [Depth];
  ipq_pkg::entry_t            new_entry;
  logic [ipq_pkg::CntW-1:0]   count_q, count_d;
  ipq_pkg::out_item_t         res_q, res_d;
  logic [Depth-1:0]           ahead;
  logic [Depth-1:0]           ins_at;
  logic                       is_raise;
  logic                       full;
  logic                       pop_ok;
  logic                       do_insert;
  logic                       do_pop;

  assign is_raise  = (item_q.kind == ipq_pkg::KindRaise);
  assign full      = (count_q == ipq_pkg::CntW'(Depth));
  assign pop_ok    = (count_q != '0) &&
                     !(item_q.interrupts_disabled && entry_q[0].maskable);
  assign do_insert = cmd_i.exec && is_raise && !full;
  assign do_pop    = cmd_i.exec && !is_raise && pop_ok;

  // New entry takes the current count as its id
  always_comb begin
    new_entry.maskable = item_q.is_maskable;
    new_entry.handler  = item_q.handler_index;
    new_entry.id       = ipq_pkg::IdW'(count_q);
  end

  // Per-slot priority compare against the new entry
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      ahead[k] = (ipq_pkg::CntW'(k) < count_q) &&
                 ipq_pkg::goes_before(new_entry.maskable, new_entry.id,
                                      entry_q[k].maskable, entry_q[k].id);
    end
  end

  // Mark slots at or after the insertion point (first hit, else the tail)
  always_comb begin
    ins_at[0] = ahead[0] || (count_q == '0);
    for (int k = 1; k < Depth; k++) begin
      ins_at[k] = ins_at[k-1] || ahead[k] || (count_q == ipq_pkg::CntW'(k));
    end
  end

  // Slot update: insert with shift up, or pop with shift down
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      entry_d[k] = entry_q[k];
      if (do_insert) begin
        if (k > 0 && ins_at[(k > 0) ? k-1 : 0]) begin
          entry_d[k] = entry_q[(k > 0) ? k-1 : 0];
        end else if (ins_at[k]) begin
          entry_d[k] = new_entry;
        end
      end else if (do_pop && (k < Depth - 1)) begin
        entry_d[k] = entry_q[(k < Depth - 1) ? k+1 : k];
      end
    end
  end

  // Count and result
  always_comb begin
    count_d = count_q;
    res_d   = res_q;
    if (cmd_i.exec) begin
      res_d = '0;
      if (is_raise) begin
        res_d.overflow = full;
        if (!full) begin
          count_d = count_q + ipq_pkg::CntW'(1);
        end
      end else if (pop_ok) begin
        res_d.dispatched       = 1'b1;
        res_d.dispatch_handler = entry_q[0].handler;
        res_d.dispatch_id      = ipq_pkg::DispIdW'(entry_q[0].id);
        count_d                = count_q - ipq_pkg::CntW'(1);
      end
      res_d.pending_count = ipq_pkg::PendW'(count_d);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_item_i;
    end
    res_q <= res_d;
    for (int k = 0; k < Depth; k++) begin
      entry_q[k] <= entry_d[k];
    end
  end

  assign out_item_o = res_q;

endmodule
`default_nettype wire

/* rtl/interrupt_priority_queue.sv */
// Top level: sorted interrupt priority queue, controller plus datapath.
// Flow: an accepted item is captured, then executed into the result register; input ready
//   drops until execute is done, so a new item is taken only after the last one has executed;
//   execute waits while an earlier result is still held on the output.
// Reset: asynchronous active low; clears the entry count, state and result valid.
//   Queue slots are not cleared; only slots below the count are ever read.
`default_nettype none
module interrupt_priority_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ipq_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ipq_pkg::out_item_t       out_item_o
);

  ipq_pkg::ipq_cmd_t cmd;

  ipq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ipq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

/* rtl/ipq_checker.sv */
// Checker: port-level assertions for the interrupt queue, bound to the top level.
`default_nettype none
module ipq_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire ipq_pkg::out_item_t  out_item_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // A result never both dispatches and overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.dispatched && out_item_o.overflow))
    else $error("dispatch and overflow together");

  // Fields without meaning read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.dispatched |->
      out_item_o.dispatch_handler == '0 && out_item_o.dispatch_id == '0)
    else $error("dispatch fields not zero");

  // Count never exceeds the depth; overflow only at a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.pending_count <= ipq_pkg::PendW'(ipq_pkg::QueueDepth) &&
      (!out_item_o.overflow ||
       out_item_o.pending_count == ipq_pkg::PendW'(ipq_pkg::QueueDepth)))
    else $error("pending count out of range");

  // Input stays closed in the cycle after an item is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted during execute");

endmodule

bind interrupt_priority_queue ipq_checker u_ipq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire

/* bench/testbench.sv */
// Testbench for the interrupt priority queue: random and directed items, shadow-queue check.
`timescale 1ns / 100ps
module testbench;

  localparam int ItemsPerPhase = 615;
  localparam int ReportLimit   = 10;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  ipq_pkg::in_item_t  in_item     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  ipq_pkg::out_item_t out_item;

  // Items waiting to be driven and results still owed by the block
  ipq_pkg::in_item_t  pend_items[$];
  ipq_pkg::out_item_t status_expect_q[$];

  // Shadow copy of the sorted interrupt queue
  logic           shadow_msk[ipq_pkg::QueueDepth];
  logic [7:0]     shadow_hnd[ipq_pkg::QueueDepth];
  logic [3:0]     shadow_id[ipq_pkg::QueueDepth];
  int             shadow_count = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int n_raise       = 0;
  int n_service     = 0;
  int n_dispatch    = 0;
  int n_overflow    = 0;
  int n_held        = 0;
  int n_full        = 0;
  int n_results     = 0;

  interrupt_priority_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #6 clk_i = ~clk_i;

  // Advance the shadow queue by one item and return the status the block owes
  function automatic ipq_pkg::out_item_t queue_step(ipq_pkg::in_item_t it);
    ipq_pkg::out_item_t res;
    int                 pos;
    logic [3:0]         nid;
    res = '0;
    if (it.kind == ipq_pkg::KindRaise) begin
      n_raise++;
      if (shadow_count >= ipq_pkg::QueueDepth) begin
        res.overflow = 1'b1;
        n_overflow++;
      end else begin
        nid = shadow_count[3:0];
        pos = 0;
        // skip entries that keep priority over the new one (stable on ties)
        while (pos < shadow_count &&
               !((it.is_maskable != shadow_msk[pos]) ? (it.is_maskable < shadow_msk[pos])
                                                      : (nid < shadow_id[pos])))
          pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_msk[i] = shadow_msk[i-1];
          shadow_hnd[i] = shadow_hnd[i-1];
          shadow_id[i]  = shadow_id[i-1];
        end
        shadow_msk[pos] = it.is_maskable;
        shadow_hnd[pos] = it.handler_index;
        shadow_id[pos]  = nid;
        shadow_count++;
        if (shadow_count == ipq_pkg::QueueDepth) n_full++;
      end
    end else begin
      n_service++;
      if (shadow_count > 0 && !(it.interrupts_disabled && shadow_msk[0])) begin
        res.dispatched       = 1'b1;
        res.dispatch_handler = shadow_hnd[0];
        res.dispatch_id      = shadow_id[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_msk[i] = shadow_msk[i+1];
          shadow_hnd[i] = shadow_hnd[i+1];
          shadow_id[i]  = shadow_id[i+1];
        end
        shadow_count--;
        n_dispatch++;
      end else if (shadow_count > 0) begin
        n_held++;
      end
    end
    res.pending_count = shadow_count[4:0];
    return res;
  endfunction

  function automatic ipq_pkg::in_item_t raise_item(logic msk, logic [7:0] hnd);
    ipq_pkg::in_item_t it;
    it = '0;
    it.kind          = ipq_pkg::KindRaise;
    it.is_maskable   = msk;
    it.handler_index = hnd;
    return it;
  endfunction

  function automatic ipq_pkg::in_item_t service_item(logic dis);
    ipq_pkg::in_item_t it;
    it = '0;
    it.kind                = ipq_pkg::KindService;
    it.interrupts_disabled = dis;
    return it;
  endfunction

  // Random item; unused fields carry noise as well
  function automatic ipq_pkg::in_item_t random_item(int raise_pct);
    ipq_pkg::in_item_t it;
    it.kind                = ($urandom_range(99) < raise_pct) ? ipq_pkg::KindRaise
                                                              : ipq_pkg::KindService;
    it.is_maskable         = 1'($urandom_range(1));
    it.handler_index       = 8'($urandom_range(255));
    it.interrupts_disabled = ($urandom_range(3) == 0);
    return it;
  endfunction

  task automatic report_error(string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Drive items: hold payload until accepted, predict on acceptance
  always @(posedge clk_i) begin
    logic take_next;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      take_next = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        status_expect_q.push_back(queue_step(in_item));
      end
      if (take_next) begin
        if (pend_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pend_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check results against the oldest expectation and toggle ready at random
  always @(posedge clk_i) begin
    ipq_pkg::out_item_t exp;
    if (rst_ni && out_valid && out_ready) begin
      n_results++;
      if (status_expect_q.size() == 0) begin
        report_error($sformatf("unexpected result %p", out_item));
      end else begin
        exp = status_expect_q.pop_front();
        if (out_item.dispatched       !== exp.dispatched       ||
            out_item.dispatch_handler !== exp.dispatch_handler ||
            out_item.dispatch_id      !== exp.dispatch_id      ||
            out_item.overflow         !== exp.overflow         ||
            out_item.pending_count    !== exp.pending_count)
          report_error($sformatf(
            "dispatched %b/%b handler %h/%h id %0d/%0d overflow %b/%b pending %0d/%0d (exp/act)",
            exp.dispatched, out_item.dispatched, exp.dispatch_handler,
            out_item.dispatch_handler, exp.dispatch_id, out_item.dispatch_id,
            exp.overflow, out_item.overflow, exp.pending_count, out_item.pending_count));
      end
    end
    out_ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Stimulus and phase control
  initial begin
    int raise_pct;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty queue, mask handling, ordering, fill and overflow
    pend_items.push_back(service_item(1'b0));
    pend_items.push_back(service_item(1'b1));
    pend_items.push_back(raise_item(1'b1, 8'hFF));
    pend_items.push_back(raise_item(1'b1, 8'h00));
    pend_items.push_back(raise_item(1'b0, 8'hAA));
    pend_items.push_back(service_item(1'b1));
    pend_items.push_back(service_item(1'b1));
    pend_items.push_back(service_item(1'b0));
    for (int i = 0; i < ipq_pkg::QueueDepth - 1; i++)
      pend_items.push_back(raise_item(i[0] ^ i[2], 8'(8'h55 << (i % 2)) ^ 8'(i)));
    pend_items.push_back(raise_item(1'b0, 8'h3C));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      raise_pct = 50;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // change the raise/service mix in bursts to swing between empty and full
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0:       raise_pct = 15;
            1:       raise_pct = 50;
            default: raise_pct = 85;
          endcase
        end
        pend_items.push_back(random_item(raise_pct));
      end
      // hold off new items until every owed result has come back
      while (pend_items.size() != 0 || in_valid || status_expect_q.size() != 0)
        @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    $display("Covered %0d raises (%0d dropped on a full queue, queue filled %0d times)",
             n_raise, n_overflow, n_full);
    $display("and %0d service requests (%0d dispatched, %0d held by mask), %0d results checked.",
             n_service, n_dispatch, n_held, n_results);
    if (mismatches == 0 && status_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run time limit
  initial begin
    #10ms;
    $display("Timeout with %0d results outstanding", status_expect_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
